// ===== rtl/core/tdq_pkg.sv =====
// ============================================================================
// tdq_pkg: shared types and constants for the sorted deadline timer queue
// Holds the command and result beats, the cell contents, the chain control and
// status groups, and the result kind codes.
// ============================================================================
package tdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [31:0] FREQ_RESET = 32'd54000000;

    // Command function codes
    localparam logic FUNC_CREATE  = 1'b0;
    localparam logic FUNC_SERVICE = 1'b1;

    // Result kind codes
    localparam logic [2:0] KIND_ACCEPTED = 3'd0;
    localparam logic [2:0] KIND_OVERFLOW = 3'd1;
    localparam logic [2:0] KIND_FULL     = 3'd2;
    localparam logic [2:0] KIND_EXPIRED  = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    typedef struct packed {
        logic        func;
        logic [63:0] now;
        logic [63:0] after_seconds;
        logic [7:0]  tag;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  expired_tag;
        logic [63:0] expired_time;
        logic [63:0] compare_value;
        logic        compare_enable;
        logic        last;
    } result_t;

    // One timer slot
    typedef struct packed {
        logic        valid;
        logic [63:0] expiry;
        logic [7:0]  tag;
    } cell_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } chain_op_t;

    typedef struct packed {
        chain_op_t   op;
        logic [63:0] ins_expiry;
        logic [7:0]  ins_tag;
        logic [63:0] now;
    } chain_ctl_t;

    typedef struct packed {
        logic        head_valid;
        logic        head_due;
        logic [63:0] head_expiry;
        logic [7:0]  head_tag;
        logic        final_enable;
        logic [63:0] final_expiry;
    } chain_stat_t;

endpackage

// ===== rtl/core/tdq_cell.sv =====
// ============================================================================
// tdq_cell: one slot of the sorted timer chain
// Keeps its timer on insert when its expiry is at or before the new one,
// otherwise takes the new timer or its left neighbor; takes its right
// neighbor on pop.
// ============================================================================
module tdq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tdq_pkg::chain_ctl_t ctl,
    input  tdq_pkg::cell_t      prev_cell,
    input  logic                prev_keep,
    input  tdq_pkg::cell_t      next_cell,
    output tdq_pkg::cell_t      slot,
    output logic                keep,
    output logic                due
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] expiry_reg;
    logic [63:0] expiry_next;
    logic [7:0]  tag_reg;
    logic [7:0]  tag_next;

    assign slot.valid  = valid_reg;
    assign slot.expiry = expiry_reg;
    assign slot.tag    = tag_reg;

    // Compare against the timer being inserted and against the service time
    assign keep = valid_reg && (expiry_reg <= ctl.ins_expiry);
    assign due  = valid_reg && (expiry_reg <= ctl.now);

    // Select the next slot contents
    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        tag_next    = tag_reg;
        case (ctl.op)
            tdq_pkg::OP_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        valid_next  = 1'b1;
                        expiry_next = ctl.ins_expiry;
                        tag_next    = ctl.ins_tag;
                    end
                    else
                    begin
                        valid_next  = prev_cell.valid;
                        expiry_next = prev_cell.expiry;
                        tag_next    = prev_cell.tag;
                    end
                end
            end
            tdq_pkg::OP_POP:
            begin
                valid_next  = next_cell.valid;
                expiry_next = next_cell.expiry;
                tag_next    = next_cell.tag;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the timer payload
    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        tag_reg    <= tag_next;
    end

endmodule

// ===== rtl/core/tdq_chain.sv =====
// ============================================================================
// tdq_chain: row of timer cells kept sorted by expiry
// Wires each cell to its neighbors and reports the head slot and the head
// that remains once every due timer has been popped.
// ============================================================================
module tdq_chain #(
    parameter int DEPTH = tdq_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdq_pkg::chain_ctl_t  ctl,
    output tdq_pkg::chain_stat_t stat
);

    tdq_pkg::cell_t   cells [DEPTH];
    logic [DEPTH-1:0] keep;
    logic [DEPTH-1:0] due;
    logic [DEPTH-1:0] sel;
    logic [63:0]      surv_expiry;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tdq_pkg::cell_t prev_c;
        tdq_pkg::cell_t next_c;
        logic           prev_keep;
        logic           prev_due;

        // Left neighbor, or the new-item slot for the head cell
        if (i == 0)
        begin : g_first
            assign prev_c    = '0;
            assign prev_keep = 1'b1;
            assign prev_due  = 1'b1;
        end
        else
        begin : g_inner
            assign prev_c    = cells[i-1];
            assign prev_keep = keep[i-1];
            assign prev_due  = due[i-1];
        end

        // Right neighbor, or an empty slot past the tail
        if (i == DEPTH - 1)
        begin : g_tail
            assign next_c = '0;
        end
        else
        begin : g_body
            assign next_c = cells[i+1];
        end

        // First slot that is not due: head after all pops
        assign sel[i] = cells[i].valid && !due[i] && prev_due;

        tdq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev_cell (prev_c),
            .prev_keep (prev_keep),
            .next_cell (next_c),
            .slot      (cells[i]),
            .keep      (keep[i]),
            .due       (due[i])
        );
    end

    // Gather the surviving head expiry
    always_comb
    begin
        surv_expiry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
                surv_expiry = surv_expiry | cells[i].expiry;
        end
    end

    assign stat.final_expiry = surv_expiry;
    assign stat.final_enable = |sel;
    assign stat.head_valid   = cells[0].valid;
    assign stat.head_due     = due[0];
    assign stat.head_expiry  = cells[0].expiry;
    assign stat.head_tag     = cells[0].tag;

endmodule

// ===== rtl/core/sorted_deadline_timer_queue_core.sv =====
// Create: ST_MUL_HI, ST_SUM, ST_INSERT, then ST_RESPOND strobes; busy drops with the strobe.
// Rejected create: result strobed from ST_SUM, once the split 64x32 expiry multiply is done.
// Service: ST_SCAN, then ST_POP strobes one expired timer per cycle and closes with done.
// Results cannot be stalled; each beat is shown for exactly one cycle.
// Reset empties the queue and loads the default counter frequency; no clearing pass.
// ============================================================================
// sorted_deadline_timer_queue_core: sorted timer queue with compare register
// Sequencer around a chain of timer cells. Computes expiry = now + delay*freq
// over two partial products, inserts it into the sorted chain unless it overflows
// or the chain is full, and pops due timers one per cycle on service.
// ============================================================================
module sorted_deadline_timer_queue_core #(
    parameter int DEPTH = tdq_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tdq_pkg::item_t   cmd,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    output logic             result_valid,
    output tdq_pkg::result_t result
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_SUM,
        ST_INSERT,
        ST_RESPOND,
        ST_SCAN,
        ST_POP
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    tdq_pkg::item_t       item_reg;
    tdq_pkg::item_t       item_next;
    logic [31:0]          freq_reg;
    logic [31:0]          freq_next;
    logic [63:0]          lo_reg;
    logic [63:0]          lo_next;
    logic [63:0]          hi_reg;
    logic [63:0]          hi_next;
    logic [63:0]          expiry_reg;
    logic [63:0]          expiry_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 fin_en_reg;
    logic                 fin_en_next;
    logic [63:0]          fin_exp_reg;
    logic [63:0]          fin_exp_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    tdq_pkg::result_t     result_reg;
    tdq_pkg::result_t     result_next;

    tdq_pkg::chain_ctl_t  ctl;
    tdq_pkg::chain_stat_t stat;
    logic [96:0]          sum;
    logic                 overflow;

    // Full product plus now; any bit above 63 means the expiry overflows
    assign sum = {1'b0, hi_reg, 32'd0} + {33'd0, lo_reg} + {33'd0, item_reg.now};
    assign overflow = |sum[96:64];

    // Drive the cell chain
    always_comb
    begin
        ctl.op         = tdq_pkg::OP_HOLD;
        ctl.ins_expiry = expiry_reg;
        ctl.ins_tag    = item_reg.tag;
        ctl.now        = item_reg.now;
        if (state_reg == ST_INSERT)
            ctl.op = tdq_pkg::OP_INSERT;
        else if (state_reg == ST_POP && stat.head_due)
            ctl.op = tdq_pkg::OP_POP;
    end

    tdq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    // Sequence one command
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        freq_next         = freq_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        expiry_next       = expiry_reg;
        count_next        = count_reg;
        fin_en_next       = fin_en_reg;
        fin_exp_next      = fin_exp_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        if (cfg_we)
            freq_next = cfg_wdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = cmd;
                    lo_next   = {32'd0, cmd.after_seconds[31:0]} * {32'd0, freq_reg};
                    if (cmd.func == tdq_pkg::FUNC_SERVICE)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI:
            begin
                hi_next    = {32'd0, item_reg.after_seconds[63:32]} * {32'd0, freq_reg};
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                expiry_next = sum[63:0];
                result_next = '0;
                result_next.compare_value  = stat.head_valid ? stat.head_expiry : 64'd0;
                result_next.compare_enable = stat.head_valid;
                result_next.last           = 1'b1;
                if (overflow)
                begin
                    result_next.kind  = tdq_pkg::KIND_OVERFLOW;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    result_next.kind  = tdq_pkg::KIND_FULL;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                count_next = count_reg + 1'b1;
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                result_next                = '0;
                result_next.kind           = tdq_pkg::KIND_ACCEPTED;
                result_next.compare_value  = stat.head_expiry;
                result_next.compare_enable = stat.head_valid;
                result_next.last           = 1'b1;
                result_valid_next          = 1'b1;
                state_next                 = ST_IDLE;
            end
            ST_SCAN:
            begin
                fin_en_next  = stat.final_enable;
                fin_exp_next = stat.final_expiry;
                state_next   = ST_POP;
            end
            ST_POP:
            begin
                result_next                = '0;
                result_next.compare_value  = fin_exp_reg;
                result_next.compare_enable = fin_en_reg;
                result_valid_next          = 1'b1;
                if (stat.head_due)
                begin
                    result_next.kind         = tdq_pkg::KIND_EXPIRED;
                    result_next.expired_tag  = stat.head_tag;
                    result_next.expired_time = stat.head_expiry;
                    count_next               = count_reg - 1'b1;
                end
                else
                begin
                    result_next.kind = tdq_pkg::KIND_DONE;
                    result_next.last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, datapath registers and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_reg         <= '0;
            freq_reg         <= tdq_pkg::FREQ_RESET;
            lo_reg           <= '0;
            hi_reg           <= '0;
            expiry_reg       <= '0;
            count_reg        <= '0;
            fin_en_reg       <= 1'b0;
            fin_exp_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            freq_reg         <= freq_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            expiry_reg       <= expiry_next;
            count_reg        <= count_next;
            fin_en_reg       <= fin_en_next;
            fin_exp_reg      <= fin_exp_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Fill count stays within the chain
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("timer count exceeds depth");

    // A done beat always closes the command
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == tdq_pkg::KIND_DONE |-> result.last)
        else $error("done beat without last");

    // The closing beat's compare enable agrees with the fill count
    a_enable_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.compare_enable == (count_reg != '0))
        else $error("compare enable disagrees with fill count");

    // Head cell is occupied exactly when the count is nonzero, checked while idle
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> stat.head_valid == (count_reg != '0))
        else $error("head slot disagrees with fill count");

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

endmodule

// ===== tb/sv/tb_sorted_deadline_timer_queue_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_sorted_deadline_timer_queue_core: self-checking bench for the timer queue
// Drives create and service commands through the start/busy handshake from a
// queue of pending actions, predicts every result beat with an independent
// sorted timer list, and checks each beat field by field as it is strobed.
// ============================================================================
module tb_sorted_deadline_timer_queue_core;

    localparam int QDEPTH = tdq_pkg::DEPTH_DEFAULT;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CFG,
        ACT_DRAIN,
        ACT_IDLE
    } act_t;

    typedef struct {
        act_t           act;
        tdq_pkg::item_t item;
        logic [31:0]    value;
    } pend_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    tdq_pkg::item_t   cmd = '0;
    logic             busy;
    logic             cfg_we = 1'b0;
    logic [31:0]      cfg_wdata = '0;
    logic             result_valid;
    tdq_pkg::result_t result;

    // Pending actions, and the beats the timer list says must come out
    pend_t            stim_q[$];
    tdq_pkg::result_t exp_results[$];

    // Predicted timer list, sorted by expiry, arrival order on ties
    logic [63:0]      tl_expiry[$];
    logic [7:0]       tl_tag[$];
    logic [31:0]      tl_freq = tdq_pkg::FREQ_RESET;

    int               beats_sent = 0;
    int               beats_taken = 0;
    int               idle_pct = 0;
    int               error_count = 0;
    int               results_seen = 0;
    int               kind_count[5] = '{default: 0};

    sorted_deadline_timer_queue_core #(
        .DEPTH(QDEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .result_valid(result_valid),
        .result(result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Work out the result beats of one accepted command
    task automatic predict_timer_beat(input tdq_pkg::item_t it);
        logic [63:0]      expiry;
        logic [63:0]      headroom;
        logic [63:0]      f64;
        int               pos;
        tdq_pkg::result_t r;
        tdq_pkg::result_t beats[$];
        f64 = {32'd0, tl_freq};
        if (it.func == tdq_pkg::FUNC_CREATE)
        begin
            r = '0;
            r.last = 1'b1;
            headroom = ~64'd0 - it.now;
            if (f64 != 0 && it.after_seconds > headroom / f64)
                r.kind = tdq_pkg::KIND_OVERFLOW;
            else if (tl_expiry.size() >= QDEPTH)
                r.kind = tdq_pkg::KIND_FULL;
            else
            begin
                expiry = it.now + it.after_seconds * f64;
                pos = 0;
                while (pos < tl_expiry.size() && tl_expiry[pos] <= expiry)
                    pos++;
                tl_expiry.insert(pos, expiry);
                tl_tag.insert(pos, it.tag);
                r.kind = tdq_pkg::KIND_ACCEPTED;
            end
            beats.push_back(r);
        end
        else
        begin
            // Pop every due head, then close with done
            while (tl_expiry.size() != 0 && tl_expiry[0] <= it.now)
            begin
                r = '0;
                r.kind = tdq_pkg::KIND_EXPIRED;
                r.expired_tag = tl_tag[0];
                r.expired_time = tl_expiry[0];
                beats.push_back(r);
                void'(tl_expiry.pop_front());
                void'(tl_tag.pop_front());
            end
            r = '0;
            r.kind = tdq_pkg::KIND_DONE;
            r.last = 1'b1;
            beats.push_back(r);
        end
        // Every beat shows the compare register after the whole step
        foreach (beats[i])
        begin
            beats[i].compare_enable = (tl_expiry.size() != 0);
            beats[i].compare_value = (tl_expiry.size() != 0) ? tl_expiry[0] : 64'd0;
            exp_results.push_back(beats[i]);
        end
    endtask

    task automatic add_item(input logic func, input logic [63:0] now,
                            input logic [63:0] after, input logic [7:0] tag);
        pend_t p;
        p.act = ACT_ITEM;
        p.item.func = func;
        p.item.now = now;
        p.item.after_seconds = after;
        p.item.tag = tag;
        p.value = '0;
        stim_q.push_back(p);
    endtask

    task automatic add_ctl(input act_t act, input logic [31:0] value);
        pend_t p;
        p.act = act;
        p.item = '0;
        p.value = value;
        stim_q.push_back(p);
    endtask

    // One random phase: mostly a coherent timeline of creates and services,
    // with noise and overflow-boundary creates mixed in
    task automatic queue_random_phase(input logic [31:0] freq, input int idle,
                                      input int count);
        logic [63:0] base;
        logic [63:0] f64;
        logic [63:0] span;
        int          roll;
        f64 = {32'd0, freq};
        add_ctl(ACT_DRAIN, 0);
        add_ctl(ACT_CFG, freq);
        add_ctl(ACT_IDLE, idle);
        base = {32'd0, $urandom};
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                add_ctl(ACT_DRAIN, 0);
            roll = $urandom_range(0, 99);
            if (roll < 50)
                add_item(tdq_pkg::FUNC_CREATE, base + 64'($urandom_range(0, 999)),
                         64'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
            else if (roll < 82)
            begin
                base = base + f64 * 64'($urandom_range(0, 2))
                       + 64'($urandom_range(0, 1999));
                add_item(tdq_pkg::FUNC_SERVICE, base, rand64(),
                         8'($urandom_range(0, 255)));
            end
            else if (roll < 90)
                add_item(tdq_pkg::FUNC_CREATE, rand64(),
                         rand64() >> $urandom_range(0, 63), 8'($urandom_range(0, 255)));
            else if (roll < 95)
                add_item(tdq_pkg::FUNC_SERVICE, rand64(), rand64(),
                         8'($urandom_range(0, 255)));
            else
            begin
                span = 64'($urandom_range(1, 3));
                add_item(tdq_pkg::FUNC_CREATE,
                         ~64'd0 - span * f64 + 64'($urandom_range(0, 1)),
                         span, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Driver: launch the next pending action at the falling edge
    always @(negedge clk)
    begin
        logic  start_nxt;
        logic  we_nxt;
        pend_t head;
        start_nxt = start;
        we_nxt = 1'b0;
        if (rst_n)
        begin
            // drop start once the beat has been taken
            if (start && beats_taken == beats_sent)
                start_nxt = 1'b0;
            if (!start_nxt && !cfg_we && stim_q.size() != 0)
            begin
                head = stim_q[0];
                case (head.act)
                    ACT_ITEM:
                    begin
                        if ($urandom_range(0, 99) >= idle_pct)
                        begin
                            cmd <= head.item;
                            start_nxt = 1'b1;
                            beats_sent++;
                            void'(stim_q.pop_front());
                        end
                    end
                    ACT_CFG:
                    begin
                        if (exp_results.size() == 0 && !busy)
                        begin
                            cfg_wdata <= head.value;
                            we_nxt = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (exp_results.size() == 0 && !busy)
                            void'(stim_q.pop_front());
                    end
                    default:
                    begin
                        idle_pct = head.value;
                        void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        start <= start_nxt;
        cfg_we <= we_nxt;
    end

    // Monitor: track config, predict accepted commands, check result beats
    always @(posedge clk)
    begin
        tdq_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                results_seen++;
                if (result.kind <= tdq_pkg::KIND_DONE)
                    kind_count[result.kind]++;
                if (exp_results.size() == 0)
                    report_error($sformatf("result beat %0d with nothing pending, kind %0d",
                                           results_seen, result.kind));
                else
                begin
                    want = exp_results.pop_front();
                    if (result.kind !== want.kind)
                        report_error($sformatf("beat %0d kind got %0d want %0d",
                                               results_seen, result.kind, want.kind));
                    if (result.expired_tag !== want.expired_tag)
                        report_error($sformatf("beat %0d expired_tag got %h want %h",
                                               results_seen, result.expired_tag,
                                               want.expired_tag));
                    if (result.expired_time !== want.expired_time)
                        report_error($sformatf("beat %0d expired_time got %h want %h",
                                               results_seen, result.expired_time,
                                               want.expired_time));
                    if (result.compare_value !== want.compare_value)
                        report_error($sformatf("beat %0d compare_value got %h want %h",
                                               results_seen, result.compare_value,
                                               want.compare_value));
                    if (result.compare_enable !== want.compare_enable)
                        report_error($sformatf("beat %0d compare_enable got %b want %b",
                                               results_seen, result.compare_enable,
                                               want.compare_enable));
                    if (result.last !== want.last)
                        report_error($sformatf("beat %0d last got %b want %b",
                                               results_seen, result.last, want.last));
                end
            end
            if (cfg_we)
                tl_freq = cfg_wdata;
            if (start && !busy)
            begin
                predict_timer_beat(cmd);
                beats_taken++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [63:0] f_rst;
        f_rst = {32'd0, tdq_pkg::FREQ_RESET};

        add_ctl(ACT_IDLE, 6);
        // empty service, then the field extremes
        add_item(tdq_pkg::FUNC_SERVICE, 64'd0, 64'd0, 8'h00);
        add_item(tdq_pkg::FUNC_CREATE, 64'd0, 64'd0, 8'h00);
        add_item(tdq_pkg::FUNC_CREATE, ~64'd0, 64'd0, 8'hFF);
        add_item(tdq_pkg::FUNC_CREATE, ~64'd0, 64'd1, 8'h11);
        add_item(tdq_pkg::FUNC_CREATE, 64'd0, ~64'd0, 8'h22);
        // equal expiries keep arrival order
        add_item(tdq_pkg::FUNC_CREATE, 64'd5, 64'd2, 8'hA5);
        add_item(tdq_pkg::FUNC_CREATE, 2 * f_rst + 5, 64'd0, 8'h5A);
        add_item(tdq_pkg::FUNC_SERVICE, 64'd0, ~64'd0, 8'hFF);
        // fill the queue, then reject on full and overflow ahead of full
        for (int i = 1; i <= 13; i++)
            add_item(tdq_pkg::FUNC_CREATE, 64'd1000 * 64'(i), 64'd1, 8'(i));
        add_item(tdq_pkg::FUNC_CREATE, 64'd0, 64'd0, 8'h33);
        add_item(tdq_pkg::FUNC_CREATE, ~64'd0, ~64'd0, 8'h44);
        // flush all sixteen at once
        add_item(tdq_pkg::FUNC_SERVICE, ~64'd0, 64'd0, 8'h00);
        // zero frequency: delay adds nothing, no overflow
        add_ctl(ACT_DRAIN, 0);
        add_ctl(ACT_CFG, 32'd0);
        add_item(tdq_pkg::FUNC_CREATE, 64'd7, ~64'd0, 8'h3C);
        add_item(tdq_pkg::FUNC_SERVICE, 64'd7, 64'd0, 8'hC3);

        queue_random_phase(32'hFFFF_FFFF, 6, 32);
        queue_random_phase(32'd1, 53, 32);
        queue_random_phase(tdq_pkg::FREQ_RESET, 0, 32);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || start || busy || exp_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d commands, %0d result beats, frequencies 0, 1, reset and max",
                 beats_taken, results_seen);
        $display("Beats: %0d accepted, %0d overflow, %0d full, %0d expired, %0d done",
                 kind_count[tdq_pkg::KIND_ACCEPTED], kind_count[tdq_pkg::KIND_OVERFLOW],
                 kind_count[tdq_pkg::KIND_FULL], kind_count[tdq_pkg::KIND_EXPIRED],
                 kind_count[tdq_pkg::KIND_DONE]);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
